FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the matrix unit RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/m4au_pkg.sv
// Package: constants, opcodes and state codes for the matrix arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
package m4au_pkg;
  localparam int unsigned MatrixDim    = 4;
  localparam int unsigned FractionBits = 16;
  localparam int unsigned WordBits     = 32;
  localparam int unsigned OpBits       = 3;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_SCL = 3'd3,
    OP_DIV = 3'd4
  } op_e;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_RD    = 6'b000010,
    ST_MAC   = 6'b000100,
    ST_ACC   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;
endpackage
`default_nettype wire

FILE: hw/rtl/matrix4_arithmetic_unit.sv
// Top level: 4x4 Q16.16 matrix arithmetic unit, RAM-backed operands
// Loads write one item per start while idle; the 16th item starts the compute.
// Add/sub/scale: each result takes a RAM read (ST_RD), then output (ST_OUT).
// Multiply: each result runs ST_RD, ST_MAC and ST_ACC, one MAC per RAM read pair.
// Divide: each result runs the bit-serial divider in ST_DIV; a zero scalar flags divide-by-zero instead.
// Reset clears the load count and state; the matrix RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module matrix4_arithmetic_unit #(
  parameter int unsigned FractionBits = m4au_pkg::FractionBits,
  parameter int unsigned WordBits     = m4au_pkg::WordBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [m4au_pkg::OpBits-1:0]   opcode_i,
  input  wire logic signed [WordBits-1:0]    a_element_i,
  input  wire logic signed [WordBits-1:0]    b_element_i,
  input  wire logic signed [WordBits-1:0]    scalar_i,
  output logic                               result_valid_o,
  output logic signed [WordBits-1:0]         result_element_o,
  output logic [$clog2(m4au_pkg::MatrixDim*m4au_pkg::MatrixDim)-1:0] element_index_o,
  output logic                               last_element_o,
  output logic                               overflow_o,
  output logic                               divide_by_zero_o
);
  localparam int unsigned MatrixDim = m4au_pkg::MatrixDim;
  localparam int unsigned Elems   = MatrixDim * MatrixDim;
  localparam int unsigned IdxBits = $clog2(Elems);
  localparam int unsigned DimBits = $clog2(MatrixDim);
  localparam int unsigned ProdBits = 2 * WordBits;
  localparam int unsigned AccBits  = ProdBits + DimBits + 1;
  localparam int unsigned NumBits  = WordBits + FractionBits;
  localparam logic signed [AccBits-1:0] MaxW =
    AccBits'({1'b0, {(WordBits-1){1'b1}}});
  localparam logic signed [AccBits-1:0] MinW = -MaxW - 1;

  m4au_pkg::state_e state_q, state_d;
  logic [IdxBits-1:0] cnt_q, cnt_d;     // load count, then output index
  logic [DimBits:0]   k_q, k_d;         // dot-product step
  logic [m4au_pkg::OpBits-1:0] op_q, op_d;
  logic signed [WordBits-1:0]  s_q, s_d;
  logic signed [AccBits-1:0]   acc_q, acc_d;
  logic signed [ProdBits-1:0]  prod_q, prod_d;
  logic                        pv_q, pv_d;
  logic signed [WordBits-1:0]  res_q, res_d;
  logic                        ovf_q, ovf_d, dz_q, dz_d, rv_q, rv_d;
  logic [IdxBits-1:0]          ridx_q, ridx_d;

  logic                        we;
  logic [IdxBits-1:0]          ra_a, ra_b;
  logic signed [WordBits-1:0]  rd_a, rd_b;
  logic                        div_start, div_done, div_neg;
  logic [NumBits-1:0]          div_q;
  logic [DimBits-1:0]          row, col, kk;
  logic signed [AccBits-1:0]   wide, qs;
  logic signed [ProdBits-1:0]  sprod;
  logic [NumBits:0]            qmag;

  assign we  = start && !busy;
  assign row = cnt_q[IdxBits-1:DimBits];
  assign col = cnt_q[DimBits-1:0];
  assign kk  = k_q[DimBits-1:0];

  m4au_ram #(.Width(WordBits), .Depth(Elems)) u_ram_a (
    .clk_i, .we_i(we), .waddr_i(cnt_q), .wdata_i(a_element_i),
    .raddr_i(ra_a), .rdata_o(rd_a)
  );
  m4au_ram #(.Width(WordBits), .Depth(Elems)) u_ram_b (
    .clk_i, .we_i(we), .waddr_i(cnt_q), .wdata_i(b_element_i),
    .raddr_i(ra_b), .rdata_o(rd_b)
  );

  m4au_div #(.NumBits(NumBits), .DenBits(WordBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i({rd_a, {FractionBits{1'b0}}}), .den_i(s_q),
    .done_o(div_done), .quot_o(div_q), .neg_o(div_neg)
  );

  function automatic logic signed [WordBits-1:0] sat(
    input logic signed [AccBits-1:0] x, output logic o);
    o = 1'b0;
    if (x > MaxW) begin
      o = 1'b1;
      return MaxW[WordBits-1:0];
    end
    if (x < MinW) begin
      o = 1'b1;
      return MinW[WordBits-1:0];
    end
    return x[WordBits-1:0];
  endfunction

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; k_d = k_q; op_d = op_q; s_d = s_q;
    acc_d = acc_q; prod_d = prod_q; pv_d = 1'b0;
    res_d = res_q; ovf_d = 1'b0; dz_d = 1'b0; rv_d = 1'b0; ridx_d = ridx_q;
    ra_a = cnt_q; ra_b = cnt_q; div_start = 1'b0;
    busy = (state_q != m4au_pkg::ST_LOAD);
    wide = '0;
    sprod = '0;
    qmag = '0;
    qs   = '0;
    case (state_q)
      m4au_pkg::ST_LOAD: begin
        if (start) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == IdxBits'(Elems - 1)) begin
            op_d = opcode_i; s_d = scalar_i;
            state_d = m4au_pkg::ST_RD;   // cnt wraps to 0
          end
        end
      end
      m4au_pkg::ST_RD: begin
        // issue read of element cnt (or first MAC pair)
        k_d = '0; acc_d = '0;
        if (op_q == m4au_pkg::OP_MUL) begin
          ra_a = {row, DimBits'(0)};
          ra_b = {DimBits'(0), col};
          k_d = (DimBits+1)'(1);
          state_d = m4au_pkg::ST_MAC;
        end else if (op_q == m4au_pkg::OP_DIV && s_q != '0) begin
          state_d = m4au_pkg::ST_DIV;
        end else begin
          state_d = m4au_pkg::ST_OUT;
        end
      end
      m4au_pkg::ST_MAC: begin
        // read pair k while multiplying data of pair k-1 (the read at k = MatrixDim is unused)
        ra_a = {row, kk};
        ra_b = {kk, col};
        prod_d = rd_a * rd_b;
        pv_d = 1'b1;
        if (pv_q) acc_d = acc_q + AccBits'(prod_q);
        if (k_q == (DimBits+1)'(MatrixDim)) begin
          state_d = m4au_pkg::ST_ACC;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      m4au_pkg::ST_ACC: begin
        if (pv_q) begin
          acc_d = acc_q + AccBits'(prod_q);
        end else begin
          wide  = acc_q >>> FractionBits;
          res_d = sat(wide, ovf_d);
          rv_d = 1'b1; ridx_d = cnt_q;
          cnt_d = cnt_q + 1'b1;
          state_d = (cnt_q == IdxBits'(Elems-1)) ? m4au_pkg::ST_LOAD : m4au_pkg::ST_RD;
        end
      end
      m4au_pkg::ST_DIV: begin
        if (k_q == '0) begin
          div_start = 1'b1;
          k_d = (DimBits+1)'(1);
        end else if (div_done) begin
          qmag = {1'b0, div_q};
          qs   = div_neg ? -AccBits'(qmag) : AccBits'(qmag);
          res_d = sat(qs, ovf_d);
          rv_d = 1'b1; ridx_d = cnt_q;
          cnt_d = cnt_q + 1'b1;
          state_d = (cnt_q == IdxBits'(Elems-1)) ? m4au_pkg::ST_LOAD : m4au_pkg::ST_RD;
        end
      end
      m4au_pkg::ST_OUT: begin
        case (op_q)
          m4au_pkg::OP_ADD: wide = AccBits'(rd_a) + AccBits'(rd_b);
          m4au_pkg::OP_SUB: wide = AccBits'(rd_a) - AccBits'(rd_b);
          m4au_pkg::OP_SCL: begin
            sprod = rd_a * s_q;
            wide  = AccBits'(sprod >>> FractionBits);
          end
          default:          wide = '0;
        endcase
        res_d = sat(wide, ovf_d);
        if (op_q == m4au_pkg::OP_DIV) begin
          dz_d  = 1'b1;
          ovf_d = 1'b0;
          res_d = (rd_a == '0) ? '0 : (rd_a[WordBits-1] ? MinW[WordBits-1:0]
                                                        : MaxW[WordBits-1:0]);
        end
        rv_d = 1'b1; ridx_d = cnt_q;
        cnt_d = cnt_q + 1'b1;
        state_d = (cnt_q == IdxBits'(Elems-1)) ? m4au_pkg::ST_LOAD : m4au_pkg::ST_RD;
      end
      default: state_d = m4au_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= m4au_pkg::ST_LOAD;
      cnt_q <= '0; k_q <= '0; pv_q <= 1'b0; rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; k_q <= k_d; pv_q <= pv_d; rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; s_q <= s_d; acc_q <= acc_d; prod_q <= prod_d;
    res_q <= res_d; ovf_q <= ovf_d; dz_q <= dz_d; ridx_q <= ridx_d;
  end

  assign result_valid_o   = rv_q;
  assign result_element_o = res_q;
  assign element_index_o  = ridx_q;
  assign last_element_o   = rv_q && (ridx_q == IdxBits'(Elems-1));
  assign overflow_o       = ovf_q;
  assign divide_by_zero_o = dz_q;

  `ASSERT_IMPL(a_no_dual_flag, clk_i, rst_ni, rv_q, !(ovf_q && dz_q))
  `ASSERT_NEXT(a_load_stall, clk_i, rst_ni, busy, !(state_q == m4au_pkg::ST_LOAD) || !busy)
  `ASSERT_IMPL(a_res_while_busy, clk_i, rst_ni, rv_q && !last_element_o, busy)
endmodule
`default_nettype wire

FILE: hw/rtl/m4au_ram.sv
// Generic single-port-write, one-read RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module m4au_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/m4au_div.sv
// Restoring signed divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module m4au_div #(
  parameter int unsigned NumBits = 48,
  parameter int unsigned DenBits = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [NumBits-1:0] num_i,
  input  wire logic [DenBits-1:0] den_i,
  output logic                    done_o,
  output logic      [NumBits-1:0] quot_o,
  output logic                    neg_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic               busy_q, busy_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [NumBits-1:0] quo_q, quo_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic               neg_q, neg_d;
  logic [DenBits:0]   trial;
  logic [DenBits:0]   shifted;
  logic [NumBits-1:0] num_mag;

  always_comb begin
    num_mag = num_i[NumBits-1] ? (~num_i + 1'b1) : num_i;
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    shifted = {rem_q[DenBits-1:0], quo_q[NumBits-1]};
    trial   = shifted - {1'b0, den_q};
    done_o  = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(NumBits);
      quo_d  = num_mag;
      rem_d  = '0;
      den_d  = den_i[DenBits-1] ? (~den_i + 1'b1) : den_i;
      neg_d  = num_i[NumBits-1] ^ den_i[DenBits-1];
    end else if (busy_q) begin
      quo_d = {quo_q[NumBits-2:0], ~trial[DenBits]};
      rem_d = trial[DenBits] ? shifted : trial;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
      end
    end
    if (busy_q && !start_i && cnt_q == CntBits'(1)) begin
      done_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // magnitude quotient; caller applies sign
  assign quot_o = {quo_q[NumBits-2:0], ~trial[DenBits]};
  assign neg_o  = neg_q;
endmodule
`default_nettype wire
